FILE: rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Shared types and constants of the bank mapper with the scanline interrupt
// counter: request and result records, page codes and IRQ control bits.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    // Request kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // CPU pages (address bits 15..12) that hold registers
    localparam logic [3:0] PAGE_PRG      = 4'd8;
    localparam logic [3:0] PAGE_PRG2_SND = 4'd9;
    localparam logic [3:0] PAGE_CHR_LO   = 4'd10;
    localparam logic [3:0] PAGE_CHR_HI   = 4'd13;
    localparam logic [3:0] PAGE_MODE     = 4'd14;
    localparam logic [3:0] PAGE_IRQ      = 4'd15;

    // Address bits that pick the second register of a page
    localparam logic [11:0] SEL_MASK = 12'h018;

    // IRQ control bit positions
    localparam int IRQ_CTL_ACK_EN = 0;
    localparam int IRQ_CTL_EN     = 1;
    localparam int IRQ_CTL_CYCLE  = 2;
    localparam logic [2:0] IRQ_CTL_MASK = 3'h7;

    // Counter and prescaler
    localparam logic [7:0]        CNT_TOP         = 8'hFF;
    localparam logic signed [9:0] PRESCALE_PERIOD = 10'sd341;
    localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;

    // Program banks
    localparam logic [1:0] PRG_SLOT_FIXED = 2'd3;
    localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;
    localparam logic [7:0] PRG0_RESET     = 8'h00;
    localparam logic [7:0] PRG1_RESET     = 8'h01;
    localparam logic [7:0] PRG2_RESET     = 8'hFE;

    // Mode register bit that maps work RAM
    localparam int MODE_RAM_BIT = 7;

    typedef struct packed {
        logic        func;
        logic [3:0]  cpu_page;
        logic [11:0] cpu_low_addr;
        logic [7:0]  write_data;
        logic [1:0]  prg_slot;
        logic [2:0]  chr_slot;
    } req_t;

    typedef struct packed {
        logic        irq_asserted;
        logic [7:0]  prg_bank;
        logic [7:0]  chr_bank;
        logic [1:0]  mirroring;
        logic        prg_ram_enabled;
        logic        sound_write;
        logic [15:0] sound_addr;
        logic [7:0]  sound_data;
    } res_t;

endpackage

FILE: rtl/bmsi_in_stage.sv
// ----------------------------------------------------------------------------
// bmsi_in_stage
// Input register: captures one request per cycle while in_ready is high and
// holds it until the mapper core hands its result on.
// ----------------------------------------------------------------------------
module bmsi_in_stage
    import bmsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    input  logic advance,
    output logic req_valid,
    output req_t req
);

    logic valid_reg;
    req_t req_reg;

    // Take a new request when empty or when the held one moves on
    assign in_ready  = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

endmodule

FILE: rtl/bmsi_core.sv
// ----------------------------------------------------------------------------
// bmsi_core
// Mapper state: bank, mode and IRQ registers. Works out the state after one
// request and the result drawn from it, and commits the state on advance.
// ----------------------------------------------------------------------------
module bmsi_core
    import bmsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  req_t req,
    output res_t res
);

    logic [7:0]        prg_reg [3];
    logic [7:0]        chr_reg [8];
    logic [7:0]        mode_reg;
    logic [2:0]        ctl_reg;
    logic [7:0]        cnt_reg;
    logic [7:0]        reload_reg;
    logic signed [9:0] pre_reg;
    logic              irq_reg;

    logic [7:0]        prg_next [3];
    logic [7:0]        chr_next [8];
    logic [7:0]        mode_next;
    logic [2:0]        ctl_next;
    logic [7:0]        cnt_next;
    logic [7:0]        reload_next;
    logic signed [9:0] pre_next;
    logic              irq_next;

    logic              second;
    logic              clock_cnt;
    logic signed [9:0] pre_dec;
    logic [3:0]        chr_page_off;
    logic [2:0]        chr_idx;
    logic              snd_w;

    assign second       = |(req.cpu_low_addr & SEL_MASK);
    assign pre_dec      = pre_reg - PRESCALE_STEP;
    assign chr_page_off = req.cpu_page - PAGE_CHR_LO;
    assign chr_idx      = {chr_page_off[1:0], second};

    // Work out the next state for the held request
    always_comb
    begin
        prg_next    = prg_reg;
        chr_next    = chr_reg;
        mode_next   = mode_reg;
        ctl_next    = ctl_reg;
        cnt_next    = cnt_reg;
        reload_next = reload_reg;
        pre_next    = pre_reg;
        irq_next    = irq_reg;
        clock_cnt   = 1'b0;
        snd_w       = 1'b0;

        if (req.func == FUNC_TICK)
        begin
            if (ctl_reg[IRQ_CTL_EN])
            begin
                if (ctl_reg[IRQ_CTL_CYCLE])
                begin
                    clock_cnt = 1'b1;
                end
                else
                begin
                    pre_next = pre_dec;
                    if (pre_dec <= 10'sd0)
                    begin
                        pre_next  = pre_dec + PRESCALE_PERIOD;
                        clock_cnt = 1'b1;
                    end
                end
            end
            // Step the counter, reload and raise IRQ on overflow
            if (clock_cnt)
            begin
                if (cnt_reg == CNT_TOP)
                begin
                    cnt_next = reload_reg;
                    irq_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end
        end
        else
        begin
            case (req.cpu_page) inside
                PAGE_PRG:
                begin
                    if (second)
                    begin
                        prg_next[1] = req.write_data;
                    end
                    else
                    begin
                        prg_next[0] = req.write_data;
                    end
                end
                PAGE_PRG2_SND:
                begin
                    if (second)
                    begin
                        snd_w = 1'b1;
                    end
                    else
                    begin
                        prg_next[2] = req.write_data;
                    end
                end
                [PAGE_CHR_LO:PAGE_CHR_HI]:
                begin
                    chr_next[chr_idx] = req.write_data;
                end
                PAGE_MODE:
                begin
                    if (second)
                    begin
                        reload_next = req.write_data;
                    end
                    else
                    begin
                        mode_next = req.write_data;
                    end
                end
                PAGE_IRQ:
                begin
                    if (second)
                    begin
                        // Acknowledge: enable follows the ack-enable bit
                        ctl_next[IRQ_CTL_EN] = ctl_reg[IRQ_CTL_ACK_EN];
                    end
                    else
                    begin
                        ctl_next = req.write_data[2:0] & IRQ_CTL_MASK;
                        if (req.write_data[IRQ_CTL_EN])
                        begin
                            cnt_next = reload_reg;
                            pre_next = PRESCALE_PERIOD;
                        end
                    end
                    irq_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Draw the result from the state after the request
    always_comb
    begin
        res.irq_asserted    = irq_next;
        res.prg_bank        = (req.prg_slot == PRG_SLOT_FIXED) ? PRG_FIXED_BANK
                                                               : prg_next[req.prg_slot];
        res.chr_bank        = chr_next[req.chr_slot];
        res.mirroring       = mode_next[1:0];
        res.prg_ram_enabled = mode_next[MODE_RAM_BIT];
        res.sound_write     = snd_w;
        res.sound_addr      = snd_w ? {req.cpu_page, req.cpu_low_addr} : 16'd0;
        res.sound_data      = snd_w ? req.write_data : 8'd0;
    end

    // Commit the state when the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_reg[0] <= PRG0_RESET;
            prg_reg[1] <= PRG1_RESET;
            prg_reg[2] <= PRG2_RESET;
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= 8'(i);
            end
            mode_reg   <= 8'd0;
            ctl_reg    <= 3'd0;
            cnt_reg    <= 8'd0;
            reload_reg <= 8'd0;
            pre_reg    <= 10'sd0;
            irq_reg    <= 1'b0;
        end
        else if (advance)
        begin
            prg_reg    <= prg_next;
            chr_reg    <= chr_next;
            mode_reg   <= mode_next;
            ctl_reg    <= ctl_next;
            cnt_reg    <= cnt_next;
            reload_reg <= reload_next;
            pre_reg    <= pre_next;
            irq_reg    <= irq_next;
        end
    end

endmodule

FILE: rtl/bank_mapper_with_scanline_irq.sv
// Data path: a request accepted into the input register has its result worked out
// by the core and captured in the output register that drives the outputs.
// Throughput: one request per cycle; the state update sits between the input
// register and the result register, so back-to-back requests only stall while
// the consumer holds out_ready low.
// Reset: rst_n clears both stage valid flags and loads the bank, mode and IRQ
// registers with their power-on values at once.
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// Cartridge bank mapper with an IRQ counter: register writes, CPU ticks and
// slot translation, with an output register towards the consumer.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq
    import bmsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [3:0]  cpu_page,
    input  logic [11:0] cpu_low_addr,
    input  logic [7:0]  write_data,
    input  logic [1:0]  prg_slot,
    input  logic [2:0]  chr_slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        irq_asserted,
    output logic [7:0]  prg_bank,
    output logic [7:0]  chr_bank,
    output logic [1:0]  mirroring,
    output logic        prg_ram_enabled,
    output logic        sound_write,
    output logic [15:0] sound_addr,
    output logic [7:0]  sound_data
);

    req_t in_req;
    req_t req;
    logic req_valid;
    logic advance;
    res_t res;
    logic out_valid_reg;
    res_t res_reg;

    assign in_req = '{func:         func,
                      cpu_page:     cpu_page,
                      cpu_low_addr: cpu_low_addr,
                      write_data:   write_data,
                      prg_slot:     prg_slot,
                      chr_slot:     chr_slot};

    // Move the held request on when the result register is free
    assign advance = req_valid && (!out_valid_reg || out_ready);

    bmsi_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    bmsi_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req),
        .res     (res)
    );

    // Hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign irq_asserted    = res_reg.irq_asserted;
    assign prg_bank        = res_reg.prg_bank;
    assign chr_bank        = res_reg.chr_bank;
    assign mirroring       = res_reg.mirroring;
    assign prg_ram_enabled = res_reg.prg_ram_enabled;
    assign sound_write     = res_reg.sound_write;
    assign sound_addr      = res_reg.sound_addr;
    assign sound_data      = res_reg.sound_data;

endmodule
